@@ design/string_to_integer_parser_macros.svh @@
// assertion helpers for the string to integer parser
`ifndef STRING_TO_INTEGER_PARSER_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_MACROS_SVH

// same-cycle implication
`define STIP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stip check failed");

// next-cycle implication
`define STIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stip check failed");

`endif

@@ design/stip_pkg.sv @@
package stip_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;
   localparam logic [7:0] UPPER_BIAS = 8'd55;
   localparam logic [7:0] LOWER_BIAS = 8'd87;

   localparam int unsigned DIGIT_W = 6;
   localparam logic [DIGIT_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [DIGIT_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [DIGIT_W-1:0] RADIX_OCT = 6'd8;
   localparam logic [DIGIT_W-1:0] RADIX_DEC = 6'd10;
   localparam logic [DIGIT_W-1:0] RADIX_HEX = 6'd16;
   localparam logic [DIGIT_W-1:0] RADIX_AUTO = 6'd0;

   localparam int unsigned OFFSET_W = 12;
   localparam int unsigned RESULT_W = 32;

   typedef struct packed {
      logic               digit_valid;
      logic [DIGIT_W-1:0] digit;
      logic               is_space;
      logic               is_sign;
      logic               minus_sign;
      logic               is_zero;
      logic               is_x;
   } char_class_type;

endpackage

@@ design/stip_char_class.sv @@
module stip_char_class
   import stip_pkg::*;
(
   input  logic [7:0]     ch,
   output char_class_type cls
);

   logic [7:0] digit_wide;

   always_comb begin
      cls = '0;
      digit_wide = '0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         digit_wide = ch - CHAR_ZERO;
         cls.digit_valid = 1'b1;
      end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
         digit_wide = ch - UPPER_BIAS;
         cls.digit_valid = 1'b1;
      end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z) begin
         digit_wide = ch - LOWER_BIAS;
         cls.digit_valid = 1'b1;
      end
      cls.digit = digit_wide[DIGIT_W-1:0];
      cls.is_space = (ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_LF) ||
                     (ch == CHAR_CR) || (ch == CHAR_VT) || (ch == CHAR_FF);
      cls.is_sign = (ch == CHAR_PLUS) || (ch == CHAR_MINUS);
      cls.minus_sign = (ch == CHAR_MINUS);
      cls.is_zero = (ch == CHAR_ZERO);
      cls.is_x = (ch == CHAR_UP_X) || (ch == CHAR_LO_X);
   end

endmodule

@@ design/string_to_integer_parser.sv @@
// chan | dir | tdata fields, lsb first                                     | transaction
// req  | in  | ch[7:0] first[8] radix_request[14:9] pad                    | one character
// rsp  | out | value[31:0] end_offset[43:32] converted[44] overflow[45] pad | one number
// one character per cycle sustained, unless a full result register stalls an ending character;
// characters wait in the input register, and a number's result is registered from there
// the multiply-add by the radix and the limit compare set the path between the two registers
// reset is synchronous, active high, and leaves the parser idle until a first character
// a full result register stalls only a character that ends a number; others pass through
`include "string_to_integer_parser_macros.svh"

module string_to_integer_parser
   import stip_pkg::*;
#(
   parameter int MAX_CHARS  = 4096,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // ch, first, radix_request, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // value, end_offset, converted, overflow, zero pad
);

   localparam int PW = $clog2(MAX_CHARS);
   localparam int PROD_W = VALUE_BITS + DIGIT_W + 1;
   localparam logic [PW-1:0] POS_LAST = PW'(MAX_CHARS - 1);

   typedef enum logic [2:0] {
      PH_IDLE, PH_SPACE, PH_SIGNED, PH_ZERO, PH_PREFIX, PH_DIGITS
   } phase_type;

   phase_type               phase_ff, phase_in, cur_phase;
   logic                    neg_ff, neg_in, cur_neg;
   logic [DIGIT_W-1:0]      radix_ff, radix_in, cur_radix, r_eff;
   logic [VALUE_BITS-1:0]   acc_ff, acc_in, cur_acc, take_acc, lim, num_val;
   logic                    sat_ff, sat_in, cur_sat, take_sat;
   logic [PW-1:0]           pos_ff, pos_in, cur_pos, pos_inc;

   logic                    in_valid_ff;
   logic [7:0]              ch_ff;
   logic                    first_ff;
   logic [DIGIT_W-1:0]      radix_req_ff;

   logic                    rsp_valid_ff;
   logic [RESULT_W-1:0]     value_ff, value_in;
   logic [OFFSET_W-1:0]     end_ff, end_in;
   logic                    conv_ff, conv_in;
   logic                    ovf_ff, ovf_in;

   char_class_type          cls;
   logic                    digit_ok, prod_over, emit, out_free, advance;
   logic [PROD_W-1:0]       prod;
   logic [PW-1:0]           end_pos;
   logic [VALUE_BITS-1:0]   emit_val;
   logic [63:0]             val_wide;
   logic [31:0]             end_wide;

   stip_char_class u_class (
      .ch  (ch_ff),
      .cls (cls)
   );

   always_comb begin
      cur_phase = first_ff ? PH_SPACE : phase_ff;
      cur_neg   = first_ff ? 1'b0 : neg_ff;
      cur_radix = first_ff ? radix_req_ff : radix_ff;
      cur_acc   = first_ff ? '0 : acc_ff;
      cur_sat   = first_ff ? 1'b0 : sat_ff;
      cur_pos   = first_ff ? '0 : pos_ff;
      pos_inc   = (cur_pos < POS_LAST) ? cur_pos + 1'b1 : cur_pos;

      if (cur_radix == RADIX_AUTO) begin
         r_eff = (cur_phase == PH_ZERO) ? RADIX_OCT : RADIX_DEC;
      end else begin
         r_eff = cur_radix;
      end

      lim = {1'b1, {(VALUE_BITS-1){1'b0}}};
      if (!cur_neg) begin
         lim = lim - 1'b1;
      end
      digit_ok  = cls.digit_valid && (r_eff >= RADIX_MIN) && (r_eff <= RADIX_MAX) &&
                  (cls.digit < r_eff);
      prod      = PROD_W'(cur_acc) * PROD_W'(r_eff) + PROD_W'(cls.digit);
      prod_over = prod > PROD_W'(lim);
      if (cur_sat) begin
         take_acc = cur_acc;
      end else if (prod_over) begin
         take_acc = lim;
      end else begin
         take_acc = prod[VALUE_BITS-1:0];
      end
      take_sat = cur_sat | prod_over;
      num_val  = cur_neg ? -cur_acc : cur_acc;

      phase_in = cur_phase;
      neg_in   = cur_neg;
      radix_in = cur_radix;
      acc_in   = cur_acc;
      sat_in   = cur_sat;
      pos_in   = (cur_phase == PH_IDLE) ? cur_pos : pos_inc;
      emit     = 1'b0;
      emit_val = '0;
      end_pos  = '0;
      conv_in  = 1'b0;
      ovf_in   = 1'b0;

      case (cur_phase)
         PH_SPACE, PH_SIGNED: begin
            if (cur_phase == PH_SPACE && cls.is_space) begin
               phase_in = PH_SPACE;
            end else if (cur_phase == PH_SPACE && cls.is_sign) begin
               neg_in   = cls.minus_sign;
               phase_in = PH_SIGNED;
            end else if ((cur_radix == RADIX_AUTO || cur_radix == RADIX_HEX) &&
                         cls.is_zero) begin
               phase_in = PH_ZERO;
            end else begin
               radix_in = r_eff;
               if (digit_ok) begin
                  acc_in   = take_acc;
                  sat_in   = take_sat;
                  phase_in = PH_DIGITS;
               end else begin
                  emit     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_ZERO: begin
            if (cls.is_x) begin
               radix_in = RADIX_HEX;
               phase_in = PH_PREFIX;
            end else begin
               radix_in = r_eff;
               if (digit_ok) begin
                  acc_in   = take_acc;
                  sat_in   = take_sat;
                  phase_in = PH_DIGITS;
               end else begin
                  emit     = 1'b1;
                  emit_val = num_val;
                  end_pos  = cur_pos;
                  conv_in  = 1'b1;
                  ovf_in   = cur_sat;
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_PREFIX: begin
            if (digit_ok) begin
               acc_in   = take_acc;
               sat_in   = take_sat;
               phase_in = PH_DIGITS;
            end else begin
               emit     = 1'b1;
               end_pos  = (cur_pos == '0) ? '0 : cur_pos - 1'b1;
               conv_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         PH_DIGITS: begin
            if (digit_ok) begin
               acc_in = take_acc;
               sat_in = take_sat;
            end else begin
               emit     = 1'b1;
               emit_val = num_val;
               end_pos  = cur_pos;
               conv_in  = 1'b1;
               ovf_in   = cur_sat;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      val_wide = 64'(emit_val);
      end_wide = 32'(end_pos);
      value_in = val_wide[RESULT_W-1:0];
      end_in   = end_wide[OFFSET_W-1:0];
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!emit || out_free);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, ovf_ff, conv_ff, end_ff, value_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         neg_ff       <= 1'b0;
         radix_ff     <= RADIX_DEC;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         pos_ff       <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff  <= 1'b1;
            ch_ff        <= req_tdata[7:0];
            first_ff     <= req_tdata[8];
            radix_req_ff <= req_tdata[14:9];
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            radix_ff <= radix_in;
            acc_ff   <= acc_in;
            sat_ff   <= sat_in;
            pos_ff   <= pos_in;
         end
         if (advance && emit) begin
            rsp_valid_ff <= 1'b1;
            value_ff     <= value_in;
            end_ff       <= end_in;
            conv_ff      <= conv_in;
            ovf_ff       <= ovf_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `STIP_ASSERT_NEXT(a_emit_loads_rsp, clock, reset, advance && emit, rsp_valid_ff)
   `STIP_ASSERT_NOW(a_no_digit_zero, clock, reset, rsp_valid_ff && !conv_ff,
                    value_ff == '0 && end_ff == '0 && !ovf_ff)
   `STIP_ASSERT_NEXT(a_idle_after_emit, clock, reset, advance && emit,
                     phase_ff == PH_IDLE)

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb
   import stip_pkg::*;
;

   localparam int unsigned CHAR_LIMIT  = 4096;
   localparam int unsigned NOT_A_DIGIT = 99;
   localparam int unsigned PHASE_CHARS = 375;

   typedef struct packed {
      logic        overflow;
      logic        converted;
      logic [11:0] end_offset;
      logic [31:0] value;
   } number_type;

   class number_scoreboard;
      typedef enum {PS_IDLE, PS_BLANK, PS_SIGN, PS_LEAD_ZERO, PS_HEX_MARK, PS_DIGITS} parse_phase_type;

      parse_phase_type phase = PS_IDLE;
      bit              is_neg;
      int unsigned     base = RADIX_DEC;
      longint unsigned magnitude;
      bit              got_digit;
      bit              clipped;
      int unsigned     position;
      number_type      pending_numbers[$];
      int              fails;

      function int unsigned digit_value(logic [7:0] c);
         if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
         if (c >= CHAR_UP_A && c <= CHAR_UP_Z) return c - UPPER_BIAS;
         if (c >= CHAR_LO_A && c <= CHAR_LO_Z) return c - LOWER_BIAS;
         return NOT_A_DIGIT;
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR ||
                c == CHAR_VT || c == CHAR_FF;
      endfunction

      function bit absorb_digit(int unsigned d);
         longint unsigned lim;
         if (base < RADIX_MIN || base > RADIX_MAX || d >= base) return 1'b0;
         got_digit = 1'b1;
         if (clipped) return 1'b1;
         lim = 64'h8000_0000;
         if (!is_neg) lim -= 1;
         if (magnitude > (lim - d) / base) begin
            magnitude = lim;
            clipped = 1'b1;
         end else begin
            magnitude = magnitude * base + d;
         end
         return 1'b1;
      endfunction

      function void push_number(logic [31:0] v, int unsigned off, bit conv, bit ovf);
         number_type n;
         n.value = v;
         n.end_offset = off[11:0];
         n.converted = conv;
         n.overflow = ovf;
         pending_numbers.push_back(n);
         phase = PS_IDLE;
      endfunction

      function void close_number(int unsigned off);
         longint unsigned v;
         v = is_neg ? 64'd0 - magnitude : magnitude;
         push_number(v[31:0], off, 1'b1, clipped);
      endfunction

      function void note_char(logic [15:0] data);
         logic [7:0] c;
         int unsigned here;
         int unsigned d;
         c = data[7:0];
         if (data[8]) begin
            phase = PS_BLANK;
            is_neg = 1'b0;
            base = data[14:9];
            magnitude = 0;
            got_digit = 1'b0;
            clipped = 1'b0;
            position = 0;
         end
         if (phase == PS_IDLE) return;
         here = position;
         if (position < CHAR_LIMIT - 1) position++;
         d = digit_value(c);

         if (phase == PS_BLANK) begin
            if (is_blank(c)) return;
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               is_neg = (c == CHAR_MINUS);
               phase = PS_SIGN;
               return;
            end
         end
         if (phase == PS_BLANK || phase == PS_SIGN) begin
            if ((base == RADIX_AUTO || base == RADIX_HEX) && c == CHAR_ZERO) begin
               got_digit = 1'b1;
               phase = PS_LEAD_ZERO;
               return;
            end
            if (base == RADIX_AUTO) base = RADIX_DEC;
            if (absorb_digit(d)) begin
               phase = PS_DIGITS;
               return;
            end
            push_number('0, 0, 1'b0, 1'b0);
            return;
         end
         if (phase == PS_LEAD_ZERO) begin
            if (c == CHAR_LO_X || c == CHAR_UP_X) begin
               base = RADIX_HEX;
               phase = PS_HEX_MARK;
               return;
            end
            if (base == RADIX_AUTO) base = RADIX_OCT;
            if (absorb_digit(d)) begin
               phase = PS_DIGITS;
               return;
            end
            close_number(here);
            return;
         end
         if (phase == PS_HEX_MARK) begin
            if (absorb_digit(d)) begin
               phase = PS_DIGITS;
               return;
            end
            // lone zero before the x is the number
            push_number('0, here > 0 ? here - 1 : 0, 1'b1, 1'b0);
            return;
         end
         if (absorb_digit(d)) return;
         close_number(here);
      endfunction

      function void check_number(logic [47:0] data);
         number_type got;
         number_type want;
         got = data[45:0];
         if (pending_numbers.size() == 0) begin
            $error("unexpected result: value %0d end_offset %0d", $signed(got.value),
                   got.end_offset);
            fails++;
            return;
         end
         want = pending_numbers.pop_front();
         if (got.value !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value), $signed(got.value));
            fails++;
         end
         if (got.end_offset !== want.end_offset) begin
            $error("end_offset: expected %0d, got %0d", want.end_offset, got.end_offset);
            fails++;
         end
         if (got.converted !== want.converted) begin
            $error("converted: expected %0b, got %0b", want.converted, got.converted);
            fails++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            fails++;
         end
      endfunction

      function int pending();
         return pending_numbers.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // ch, first, radix_request, zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // value, end_offset, converted, overflow, zero pad

   int send_idle_pct = 0;
   int stall_pct = 0;
   int chars_sent = 0;
   int idle_plan[4] = '{0, 50, 0, 38};
   int stall_plan[4] = '{0, 0, 50, 38};

   number_scoreboard sb = new;

   string_to_integer_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_char(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_number(rsp_tdata);
      end
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic send_char(logic [7:0] c, bit first, logic [5:0] radix);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, radix, first, c};
      do @(posedge clock); while (req_tready !== 1'b1);
      chars_sent++;
   endtask

   task automatic send_text(string s, logic [5:0] radix);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0, radix);
   endtask

   task automatic put_char(logic [7:0] c, inout bit fresh, input logic [5:0] radix);
      send_char(c, fresh, fresh ? radix : 6'($urandom_range(0, 63)));
      fresh = 1'b0;
   endtask

   function automatic logic [7:0] digit_char(int unsigned d);
      if (d < 10) return CHAR_ZERO + 8'(d);
      if ($urandom_range(0, 1)) return UPPER_BIAS + 8'(d);
      return LOWER_BIAS + 8'(d);
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 5))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_LF;
         3: return CHAR_CR;
         4: return CHAR_VT;
         default: return CHAR_FF;
      endcase
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // one string: optional blanks, sign and prefix, digits of the base, an optional ending; at times raw bytes
   task automatic send_number();
      logic [5:0] r;
      int unsigned eff;
      int unsigned sel;
      int unsigned n;
      bit fresh;
      fresh = 1'b1;
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 6))
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
                      6'($urandom_range(0, 63)));
         return;
      end
      case ($urandom_range(0, 9))
         0, 1: r = RADIX_AUTO;
         2: r = RADIX_DEC;
         3: r = RADIX_HEX;
         4: r = RADIX_OCT;
         5: r = RADIX_MIN;
         6: r = RADIX_MAX;
         7, 8: r = 6'($urandom_range(2, 36));
         default: r = 6'($urandom_range(0, 63));
      endcase
      if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 3)) put_char(blank_char(), fresh, r);
      case ($urandom_range(0, 2))
         1: put_char(CHAR_PLUS, fresh, r);
         2: put_char(CHAR_MINUS, fresh, r);
         default: ;
      endcase
      sel = $urandom_range(0, 3);
      if ((r == RADIX_AUTO || r == RADIX_HEX) && sel == 0) begin
         put_char(CHAR_ZERO, fresh, r);
         put_char($urandom_range(0, 1) ? CHAR_LO_X : CHAR_UP_X, fresh, r);
         eff = RADIX_HEX;
      end else if (r == RADIX_AUTO && sel == 1) begin
         put_char(CHAR_ZERO, fresh, r);
         eff = RADIX_OCT;
      end else if (r == RADIX_AUTO) begin
         eff = RADIX_DEC;
      end else begin
         eff = r;
      end
      if (eff < RADIX_MIN || eff > RADIX_MAX) eff = RADIX_DEC;
      sel = $urandom_range(0, 99);
      if (sel < 80) n = $urandom_range(0, 8);
      else if (sel < 95) n = $urandom_range(9, 14);
      else n = $urandom_range(15, 40);
      repeat (n) put_char(digit_char($urandom_range(0, eff - 1)), fresh, r);
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
         put_char($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)), fresh, r);
         if (sel == 7) repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(0, 255)), fresh, r);
      end
   endtask

   initial begin
      int start;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_char(CHAR_ZERO + 8'd5, 1'b0, RADIX_DEC);
      send_text("\t-42", RADIX_DEC);
      send_char(8'h00, 1'b0, RADIX_AUTO);
      send_text("0x1Fg", RADIX_AUTO);
      send_text("0xz", RADIX_HEX);
      send_text("+", RADIX_DEC);
      send_char(8'h00, 1'b0, RADIX_AUTO);
      send_char(CHAR_ZERO + 8'd5, 1'b0, RADIX_DEC);
      send_text("017", RADIX_AUTO);
      send_char(8'h00, 1'b0, RADIX_AUTO);
      send_text("9", 6'd1);
      send_text("Z", 6'd63);
      send_text("12", RADIX_DEC);
      send_text("z", RADIX_MAX);
      send_char(8'hFF, 1'b0, 6'd63);
      send_text("-ZZZZZZZ.", RADIX_MAX);
      send_text("7fffffff", RADIX_HEX);
      send_char(8'h00, 1'b0, RADIX_AUTO);
      drain();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p];
         stall_pct = stall_plan[p];
         start = chars_sent;
         while (chars_sent - start < PHASE_CHARS) send_number();
         drain();
      end

      send_idle_pct = 0;
      stall_pct = 0;
      drain();
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
